// ----- hw/rtl/u8dec_pkg.sv -----
// ----------------------------------------------------------------------------
// u8dec_pkg
// shared types and constants of the utf-8 to ucs-2 stream decoder
// ----------------------------------------------------------------------------
package u8dec_pkg;

   localparam int COUNT_BITS = 16;
   localparam int CAP_BITS   = 16;
   localparam int LIM_BITS   = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;

   localparam int BYTE_BITS  = 8;
   localparam int CODE_BITS  = 16;
   localparam int KIND_BITS  = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 16'hFFFF;

   // item kinds on the result channel
   localparam logic [KIND_BITS-1:0] KIND_CHAR  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_ERROR = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_TERM  = 2'd2;

   // work handed from front to back; an error expands to error slot + terminator
   typedef enum logic [1:0] {
      OP_CHAR,
      OP_ERROR,
      OP_TERM
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [CODE_BITS-1:0] code;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

endpackage

// ----- hw/rtl/u8dec_front.sv -----
// ----------------------------------------------------------------------------
// u8dec_front
// byte classifier and sequence assembler; hands at most one op per byte to the queue
// ----------------------------------------------------------------------------
module u8dec_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [u8dec_pkg::CAP_BITS-1:0] csr_wdata,
   input  logic                          byte_valid,
   input  logic [u8dec_pkg::BYTE_BITS-1:0] byte_data,
   input  logic                          queue_full,
   output logic                          byte_ready,
   output u8dec_pkg::push_type           push
);
   import u8dec_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_COLLECT,
      PH_DISCARD
   } phase_type;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   phase_type             phase_ff, phase_in;
   logic [2:0]            left_ff, left_in;
   logic [2:0]            class_ff, class_in;
   logic [CODE_BITS-1:0]  acc_ff, acc_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [CAP_BITS-1:0]   cap_ff;

   logic                  take;
   logic                  is_cont;
   logic                  byte_nul;
   logic [CAP_BITS-1:0]   lim;
   logic                  limit_hit;
   logic [CODE_BITS-1:0]  acc_cont;
   logic [2:0]            left_dec;
   logic [2:0]            lead_class;
   logic [COUNT_BITS-1:0] cnt_inc;

   assign byte_ready = !queue_full;
   assign take       = byte_valid && byte_ready;
   assign is_cont    = (byte_data[7:6] == 2'b10);
   assign byte_nul   = (byte_data == '0);
   assign lim        = (cap_ff == '0) ? '0 : cap_ff - 1'b1;
   assign limit_hit  = (LIM_BITS'(cnt_ff) >= LIM_BITS'(lim)) || (cnt_ff == CNT_MAX);
   assign acc_cont   = {acc_ff[CODE_BITS-7:0], byte_data[5:0]};
   assign left_dec   = (left_ff != '0) ? left_ff - 3'd1 : 3'd0;
   assign cnt_inc    = (cnt_ff != CNT_MAX) ? cnt_ff + 1'b1 : cnt_ff;

   always_comb begin
      priority casez (byte_data)
         8'b110?????: lead_class = 3'd1;
         8'b1110????: lead_class = 3'd2;
         8'b11110???: lead_class = 3'd3;
         8'b111110??: lead_class = 3'd4;
         8'b1111110?: lead_class = 3'd5;
         default:     lead_class = 3'd6;
      endcase
   end

   always_comb begin
      phase_in   = phase_ff;
      left_in    = left_ff;
      class_in   = class_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      push.valid = 1'b0;
      push.entry = '{op: OP_CHAR, code: '0};
      if (take) begin
         unique case (phase_ff)
            PH_DISCARD: begin
               if (byte_nul) begin
                  phase_in = PH_IDLE;
                  cnt_in   = '0;
               end
            end
            PH_COLLECT: begin
               if (!is_cont) begin
                  push.valid = 1'b1;
                  push.entry = '{op: OP_ERROR, code: '0};
                  cnt_in     = '0;
                  left_in    = '0;
                  phase_in   = byte_nul ? PH_IDLE : PH_DISCARD;
               end else begin
                  acc_in  = acc_cont;
                  left_in = left_dec;
                  if (left_dec == '0) begin
                     push.valid = 1'b1;
                     if ((class_ff == 3'd1) && (acc_cont[10:0] >= 11'h080)) begin
                        push.entry = '{op: OP_CHAR, code: CODE_BITS'(acc_cont[10:0])};
                        cnt_in     = cnt_inc;
                        phase_in   = PH_IDLE;
                     end else if ((class_ff == 3'd2) && (acc_cont >= 16'h0800)) begin
                        push.entry = '{op: OP_CHAR, code: acc_cont};
                        cnt_in     = cnt_inc;
                        phase_in   = PH_IDLE;
                     end else begin
                        // overlong form or a sequence beyond three bytes
                        push.entry = '{op: OP_ERROR, code: '0};
                        cnt_in     = '0;
                        left_in    = '0;
                        phase_in   = PH_DISCARD;
                     end
                  end
               end
            end
            default: begin
               // idle, and the unused phase code behaves the same
               if (byte_nul || limit_hit) begin
                  push.valid = 1'b1;
                  push.entry = '{op: OP_TERM, code: '0};
                  cnt_in     = '0;
                  phase_in   = byte_nul ? PH_IDLE : PH_DISCARD;
               end else if (!byte_data[7]) begin
                  push.valid = 1'b1;
                  push.entry = '{op: OP_CHAR, code: CODE_BITS'(byte_data[6:0])};
                  cnt_in     = cnt_inc;
                  phase_in   = PH_IDLE;
               end else begin
                  class_in = lead_class;
                  left_in  = lead_class;
                  acc_in   = CODE_BITS'(byte_data);
                  phase_in = PH_COLLECT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         left_ff  <= '0;
         class_ff <= '0;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         class_ff <= class_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         if (csr_wen) begin
            cap_ff <= csr_wdata;
         end
      end
   end

endmodule

// ----- hw/rtl/u8dec_queue.sv -----
// ----------------------------------------------------------------------------
// u8dec_queue
// short fifo of decoded ops between front and back
// ----------------------------------------------------------------------------
module u8dec_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  u8dec_pkg::push_type  push,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output u8dec_pkg::entry_type head
);
   import u8dec_pkg::*;

   localparam logic [QCNT_BITS-1:0] DEPTH_CNT = QCNT_BITS'(QUEUE_DEPTH);
   localparam logic [QPTR_BITS-1:0] LAST_PTR  = QPTR_BITS'(QUEUE_DEPTH - 1);

   entry_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == DEPTH_CNT);
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push.valid) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("pop from empty queue");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_CNT) else $error("queue count out of range");

endmodule

// ----- hw/rtl/u8dec_back.sv -----
// ----------------------------------------------------------------------------
// u8dec_back
// expands queued ops into result transfers held in an output register
// ----------------------------------------------------------------------------
module u8dec_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             queue_empty,
   input  u8dec_pkg::entry_type             head,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [u8dec_pkg::CODE_BITS-1:0]  rsp_code,
   output logic [u8dec_pkg::KIND_BITS-1:0]  rsp_kind,
   output logic                             rsp_last
);
   import u8dec_pkg::*;

   logic                 valid_ff;
   logic [CODE_BITS-1:0] code_ff;
   logic [KIND_BITS-1:0] kind_ff;
   logic                 last_ff;
   logic                 term_pending_ff;
   logic                 load;

   assign load = !valid_ff || rsp_tready;
   assign pop  = load && !term_pending_ff && !queue_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         term_pending_ff <= 1'b0;
      end else if (load) begin
         if (term_pending_ff) begin
            valid_ff        <= 1'b1;
            term_pending_ff <= 1'b0;
         end else begin
            valid_ff        <= !queue_empty;
            term_pending_ff <= !queue_empty && (head.op == OP_ERROR);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (term_pending_ff) begin
            code_ff <= '0;
            kind_ff <= KIND_TERM;
            last_ff <= 1'b1;
         end else begin
            code_ff <= head.code;
            unique case (head.op)
               OP_CHAR: begin
                  kind_ff <= KIND_CHAR;
                  last_ff <= 1'b0;
               end
               OP_ERROR: begin
                  kind_ff <= KIND_ERROR;
                  last_ff <= 1'b0;
               end
               OP_TERM: begin
                  kind_ff <= KIND_TERM;
                  last_ff <= 1'b1;
               end
               default: begin
                  kind_ff <= KIND_TERM;
                  last_ff <= 1'b1;
               end
            endcase
         end
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_code   = code_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_last   = last_ff;

   a_pending_holds_error: assert property (@(posedge clock) disable iff (reset)
      term_pending_ff |-> (valid_ff && (kind_ff == KIND_ERROR)))
      else $error("terminator pending without error slot shown");
   a_error_then_term: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_tready && (kind_ff == KIND_ERROR)) |=>
      (valid_ff && (kind_ff == KIND_TERM)))
      else $error("error slot not followed by terminator");
   a_last_only_term: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (last_ff == (kind_ff == KIND_TERM)))
      else $error("last flag disagrees with item kind");

endmodule

// ----- hw/rtl/utf8_to_ucs2_stream_decoder_core.sv -----
// ----------------------------------------------------------------------------
// utf8_to_ucs2_stream_decoder_core
// utf-8 byte stream in, ucs-2 code units with error and terminator items out
// ----------------------------------------------------------------------------
// an op completed by a byte is written into the queue, then loaded into the output register
// throughput: one byte per cycle while the queue has room; an error adds a terminator item
// the front fills a 4-entry op queue; the back drains one op a cycle when not stalled
// reset: synchronous, active high; idle awaiting a lead byte, counters cleared,
// capacity register back to 65535, queue and output register empty
// ----------------------------------------------------------------------------
module utf8_to_ucs2_stream_decoder_core (
   input  logic        clock,
   input  logic        reset,
   // capacity register, output slots per string including terminator
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata,
   // byte stream in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   // code unit stream out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] code_unit
   output logic [1:0]  rsp_tuser,   // [1:0] item_kind
   output logic        rsp_tlast    // last, set on the terminator
);
   import u8dec_pkg::*;

   push_type  push;
   entry_type head;
   logic      queue_full;
   logic      queue_empty;
   logic      pop;

   // front: classify each byte, assemble sequences, track the character limit
   u8dec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .byte_valid (req_tvalid),
      .byte_data  (req_tdata),
      .queue_full (queue_full),
      .byte_ready (req_tready),
      .push       (push)
   );

   // decoupling queue, lets the byte side run while the result side stalls
   u8dec_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .empty (queue_empty),
      .head  (head)
   );

   // back: one result transfer per cycle from the output register while rsp_tready is high
   u8dec_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_code    (rsp_tdata),
      .rsp_kind    (rsp_tuser),
      .rsp_last    (rsp_tlast)
   );

endmodule
